/* rtl/core/fct_pkg.sv */
// fct_pkg: shared constants for the frustum cull test unit.
// Plane register layout, request type codes and plane register indexes.
// No dependencies; used by fct_cell and frustum_cull_test_unit.
`timescale 1ns / 1ps

package fct_pkg;

    // Plane count and register index width
    localparam int NUM_PLANES     = 6;
    localparam int CFG_IDX_BITS   = 3;
    localparam int CFG_DATA_BITS  = 64;

    // Plane register layout: nx, ny, nz Q1.14 then d, 16 bits each
    localparam int COEF_BITS      = 16;
    localparam int NORM_FRAC      = 14;

    // Default coordinate width
    localparam int DEF_COORD_BITS = 16;

    // Request type codes
    localparam logic REQ_SPHERE = 1'b0;
    localparam logic REQ_BOX    = 1'b1;

    // Plane register indexes
    localparam logic [CFG_IDX_BITS-1:0] PLANE_LEFT   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] PLANE_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] PLANE_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] PLANE_TOP    = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] PLANE_NEAR   = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] PLANE_FAR    = 3'd5;

    // Cell order along the chain
    localparam logic [CFG_IDX_BITS-1:0] PLANE_IDX [NUM_PLANES] = '{
        PLANE_LEFT, PLANE_RIGHT, PLANE_BOTTOM, PLANE_TOP, PLANE_NEAR, PLANE_FAR
    };

endpackage

/* rtl/core/fct_cell.sv */
// fct_cell: one plane of the culling chain. Holds its plane register and
// tests each passing item against it in two register stages.
// Depends on fct_pkg.
`timescale 1ns / 1ps

module fct_cell #(
    parameter int COORD_BITS = fct_pkg::DEF_COORD_BITS,
    parameter logic [fct_pkg::CFG_IDX_BITS-1:0] CELL_ID = fct_pkg::PLANE_LEFT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write
    input  logic                               cfg_valid,
    input  logic [fct_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // upstream neighbor
    input  logic                               up_valid,
    output logic                               up_ready,
    input  logic                               up_type,
    input  logic signed [COORD_BITS-1:0]       up_lo [3],
    input  logic signed [COORD_BITS-1:0]       up_hi [3],
    input  logic [COORD_BITS-2:0]              up_radius,
    input  logic                               up_visible,
    // downstream neighbor
    output logic                               dn_valid,
    input  logic                               dn_ready,
    output logic                               dn_type,
    output logic signed [COORD_BITS-1:0]       dn_lo [3],
    output logic signed [COORD_BITS-1:0]       dn_hi [3],
    output logic [COORD_BITS-2:0]              dn_radius,
    output logic                               dn_visible
);

    localparam int CB      = fct_pkg::COEF_BITS;
    localparam int PROD_W  = COORD_BITS + CB;
    localparam int BIAS_W  = ((COORD_BITS > CB) ? COORD_BITS : CB) + 1;
    localparam int TERM_W  = ((PROD_W > BIAS_W + fct_pkg::NORM_FRAC) ?
                              PROD_W : BIAS_W + fct_pkg::NORM_FRAC);
    localparam int ACC_W   = TERM_W + 2;

    // Plane register
    logic [fct_pkg::CFG_DATA_BITS-1:0] plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (cfg_valid && (cfg_index == CELL_ID))
        begin
            plane_reg <= cfg_data;
        end
    end

    // Handshake between stages
    logic a_valid_reg, b_valid_reg;
    logic a_ready, b_ready, a_load, b_load;

    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign a_load   = up_valid && a_ready;
    assign b_load   = a_valid_reg && b_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= up_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    // Stage A: corner pick, three products, offset plus radius for spheres
    logic signed [PROD_W-1:0] prod_next [3];
    logic signed [BIAS_W-1:0] bias_next;

    always_comb
    begin
        logic signed [CB-1:0]     nrm;
        logic signed [PROD_W-1:0] nrm_ext;
        logic signed [PROD_W-1:0] pt_ext;
        logic signed [CB-1:0]     d_val;
        logic signed [BIAS_W-1:0] d_ext;
        logic signed [BIAS_W-1:0] r_ext;
        for (int k = 0; k < 3; k++)
        begin
            nrm     = plane_reg[CB*k +: CB];
            nrm_ext = nrm;
            // zero component counts as positive: take the maximum
            if ((up_type == fct_pkg::REQ_BOX) && !nrm[CB-1])
            begin
                pt_ext = up_hi[k];
            end
            else
            begin
                pt_ext = up_lo[k];
            end
            prod_next[k] = nrm_ext * pt_ext;
        end
        d_val = plane_reg[CB*3 +: CB];
        d_ext = d_val;
        r_ext = signed'(BIAS_W'(up_radius));
        // sphere: n.c + d < -r  is  n.c + (d + r) < 0
        bias_next = (up_type == fct_pkg::REQ_SPHERE) ? (d_ext + r_ext) : d_ext;
    end

    logic signed [PROD_W-1:0]     a_prod_reg [3];
    logic signed [BIAS_W-1:0]     a_bias_reg;
    logic                         a_type_reg;
    logic signed [COORD_BITS-1:0] a_lo_reg [3];
    logic signed [COORD_BITS-1:0] a_hi_reg [3];
    logic [COORD_BITS-2:0]        a_radius_reg;
    logic                         a_visible_reg;

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            a_prod_reg    <= prod_next;
            a_bias_reg    <= bias_next;
            a_type_reg    <= up_type;
            a_lo_reg      <= up_lo;
            a_hi_reg      <= up_hi;
            a_radius_reg  <= up_radius;
            a_visible_reg <= up_visible;
        end
    end

    // Stage B: accumulate and test the sign
    logic visible_next;

    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] term;
        acc = '0;
        for (int k = 0; k < 3; k++)
        begin
            term = a_prod_reg[k];
            acc  = acc + term;
        end
        term = a_bias_reg;
        acc  = acc + (term <<< fct_pkg::NORM_FRAC);
        visible_next = a_visible_reg && !acc[ACC_W-1];
    end

    logic                         b_type_reg;
    logic signed [COORD_BITS-1:0] b_lo_reg [3];
    logic signed [COORD_BITS-1:0] b_hi_reg [3];
    logic [COORD_BITS-2:0]        b_radius_reg;
    logic                         b_visible_reg;

    always_ff @(posedge clk)
    begin
        if (b_load)
        begin
            b_type_reg    <= a_type_reg;
            b_lo_reg      <= a_lo_reg;
            b_hi_reg      <= a_hi_reg;
            b_radius_reg  <= a_radius_reg;
            b_visible_reg <= visible_next;
        end
    end

    assign dn_valid   = b_valid_reg;
    assign dn_type    = b_type_reg;
    assign dn_lo      = b_lo_reg;
    assign dn_hi      = b_hi_reg;
    assign dn_radius  = b_radius_reg;
    assign dn_visible = b_visible_reg;

endmodule

/* rtl/core/frustum_cull_test_unit.sv */
// frustum_cull_test_unit: top level of the sphere / box frustum culling test.
// A chain of six fct_cell instances, one per plane. Depends on fct_pkg, fct_cell.
//
// Usage:
//   Configuration: write plane registers through cfg_valid / cfg_ready with
//   cfg_index (0 left .. 5 far) and cfg_data; cfg_ready is always high and
//   writes to indexes above 5 are dropped. Write only while no request is in
//   flight. Reset clears every plane to zero, which accepts everything.
//   Requests: one transfer on req_valid / req_stall carries req_type
//   (0 sphere, 1 box), the first and second corners and sphere_radius.
//   Results: one transfer on res_valid / res_stall carries visible.
//   Each request passes through every plane cell's product stage and then its
//   accumulate / sign stage. Throughput is one request per cycle while req_stall
//   is low; each cell handles one plane and all six work on different requests at once.
//   When the receiver stalls, results stay in the chain and empty stages
//   still take new requests; req_stall rises only once the chain is full
//   back to the output register. Reset empties the chain.
`timescale 1ns / 1ps

module frustum_cull_test_unit #(
    parameter int COORD_BITS = fct_pkg::DEF_COORD_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [fct_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fct_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // request channel
    input  logic                               req_valid,
    output logic                               req_stall,
    input  logic                               req_type,
    input  logic signed [COORD_BITS-1:0]       first_x,
    input  logic signed [COORD_BITS-1:0]       first_y,
    input  logic signed [COORD_BITS-1:0]       first_z,
    input  logic signed [COORD_BITS-1:0]       second_x,
    input  logic signed [COORD_BITS-1:0]       second_y,
    input  logic signed [COORD_BITS-1:0]       second_z,
    input  logic [COORD_BITS-2:0]              sphere_radius,
    // result channel
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic                               visible
);

    localparam int NP = fct_pkg::NUM_PLANES;

    // Links between neighboring cells; link 0 is the request port
    logic                         lk_valid   [NP+1];
    logic                         lk_ready   [NP+1];
    logic                         lk_type    [NP+1];
    logic signed [COORD_BITS-1:0] lk_lo      [NP+1][3];
    logic signed [COORD_BITS-1:0] lk_hi      [NP+1][3];
    logic [COORD_BITS-2:0]        lk_radius  [NP+1];
    logic                         lk_visible [NP+1];

    assign cfg_ready = 1'b1;

    // Chain entry
    assign lk_valid[0]   = req_valid;
    assign req_stall     = !lk_ready[0];
    assign lk_type[0]    = req_type;
    assign lk_lo[0][0]   = first_x;
    assign lk_lo[0][1]   = first_y;
    assign lk_lo[0][2]   = first_z;
    assign lk_hi[0][0]   = second_x;
    assign lk_hi[0][1]   = second_y;
    assign lk_hi[0][2]   = second_z;
    assign lk_radius[0]  = sphere_radius;
    assign lk_visible[0] = 1'b1;

    // Row of plane cells
    for (genvar i = 0; i < NP; i++)
    begin : g_cell
        fct_cell #(
            .COORD_BITS (COORD_BITS),
            .CELL_ID    (fct_pkg::PLANE_IDX[i])
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cfg_valid  (cfg_valid && cfg_ready),
            .cfg_index  (cfg_index),
            .cfg_data   (cfg_data),
            .up_valid   (lk_valid[i]),
            .up_ready   (lk_ready[i]),
            .up_type    (lk_type[i]),
            .up_lo      (lk_lo[i]),
            .up_hi      (lk_hi[i]),
            .up_radius  (lk_radius[i]),
            .up_visible (lk_visible[i]),
            .dn_valid   (lk_valid[i+1]),
            .dn_ready   (lk_ready[i+1]),
            .dn_type    (lk_type[i+1]),
            .dn_lo      (lk_lo[i+1]),
            .dn_hi      (lk_hi[i+1]),
            .dn_radius  (lk_radius[i+1]),
            .dn_visible (lk_visible[i+1])
        );
    end

    // Chain exit: last cell's output stage is the result register
    assign lk_ready[NP] = !res_stall;
    assign res_valid    = lk_valid[NP];
    assign visible      = lk_visible[NP];

    // The chain only backs up when a result is held at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !req_stall)
        else $error("request stalled with no result waiting");

    assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall))
        else $error("request stalled while output drains");

    // A stalled result held at the output keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(visible)))
        else $error("held result changed");

endmodule

/* verif/testbench.sv */
// testbench: self-checking bench for frustum_cull_test_unit, sphere and box culling.
// Predicts visibility from a local copy of the six plane registers; uses fct_pkg
// and the frustum_cull_test_unit RTL.
`timescale 1ns / 1ps

module testbench;

    localparam int CW                 = fct_pkg::DEF_COORD_BITS;
    localparam int IDLE_LIMIT         = 5000;
    localparam int SETTLE_CYCLES      = 24;
    localparam int ITEMS_PER_SETTING  = 66;
    localparam int SETTINGS_PER_PHASE = 4;
    localparam int ONE_Q14            = 16384;

    // Indexes past the last plane, written to check that they are dropped
    localparam logic [fct_pkg::CFG_IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [fct_pkg::CFG_IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    typedef enum int {
        STYLE_ZERO, STYLE_SCENE, STYLE_NOISE, STYLE_EXTREME
    } plane_style_t;

    typedef struct {
        logic                 req_type;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] first_z;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
        logic signed [CW-1:0] second_z;
        logic [CW-2:0]        radius;
    } request_t;

    // DUT connections; the bench-driven inputs are known from time zero
    logic                                 clk           = 1'b0;
    logic                                 rst_n         = 1'b0;
    logic                                 cfg_valid     = 1'b0;
    logic                                 cfg_ready;
    logic [fct_pkg::CFG_IDX_BITS-1:0]     cfg_index     = '0;
    logic [fct_pkg::CFG_DATA_BITS-1:0]    cfg_data      = '0;
    logic                                 req_valid     = 1'b0;
    logic                                 req_stall;
    logic                                 req_type      = fct_pkg::REQ_SPHERE;
    logic signed [CW-1:0]                 first_x       = '0;
    logic signed [CW-1:0]                 first_y       = '0;
    logic signed [CW-1:0]                 first_z       = '0;
    logic signed [CW-1:0]                 second_x      = '0;
    logic signed [CW-1:0]                 second_y      = '0;
    logic signed [CW-1:0]                 second_z      = '0;
    logic [CW-2:0]                        sphere_radius = '0;
    logic                                 res_valid;
    logic                                 res_stall     = 1'b0;
    logic                                 visible;

    // Bench state
    logic [fct_pkg::CFG_DATA_BITS-1:0]    plane_regs [fct_pkg::NUM_PLANES];
    bit                                   visible_q [$];
    int                                   gap_pct      = 0;
    int                                   stall_pct    = 0;
    int                                   error_count  = 0;
    int                                   result_count = 0;
    int                                   idle_cycles  = 0;

    frustum_cull_test_unit #(
        .COORD_BITS (CW)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .req_type      (req_type),
        .first_x       (first_x),
        .first_y       (first_y),
        .first_z       (first_z),
        .second_x      (second_x),
        .second_y      (second_y),
        .second_z      (second_z),
        .sphere_radius (sphere_radius),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .visible       (visible)
    );

    always #5 clk = ~clk;

    // Visibility of one request against the current planes, exact fixed point
    function automatic bit cull_visible(request_t r);
        longint nx;
        longint ny;
        longint nz;
        longint d;
        longint px;
        longint py;
        longint pz;
        longint acc;
        longint rad_q;
        bit     vis;
        vis   = 1'b1;
        rad_q = longint'(r.radius) << fct_pkg::NORM_FRAC;
        for (int i = 0; i < fct_pkg::NUM_PLANES; i++)
        begin
            nx = $signed(plane_regs[i][15:0]);
            ny = $signed(plane_regs[i][31:16]);
            nz = $signed(plane_regs[i][47:32]);
            d  = $signed(plane_regs[i][63:48]);
            if (r.req_type == fct_pkg::REQ_BOX)
            begin
                // positive vertex: zero component picks the max corner
                px = (nx >= 0) ? r.second_x : r.first_x;
                py = (ny >= 0) ? r.second_y : r.first_y;
                pz = (nz >= 0) ? r.second_z : r.first_z;
            end
            else
            begin
                px = r.first_x;
                py = r.first_y;
                pz = r.first_z;
            end
            acc = nx * px + ny * py + nz * pz + (d <<< fct_pkg::NORM_FRAC);
            if (r.req_type == fct_pkg::REQ_BOX)
            begin
                if (acc < 0)
                    vis = 1'b0;
            end
            else if (acc < -rad_q)
            begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    // Track plane writes and predict each accepted request
    always @(posedge clk or negedge rst_n)
    begin : track_inputs
        request_t r;
        if (!rst_n)
        begin
            foreach (plane_regs[i])
                plane_regs[i] = '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index < fct_pkg::NUM_PLANES)
                plane_regs[cfg_index] = cfg_data;
            if (req_valid && !req_stall)
            begin
                r.req_type = req_type;
                r.first_x  = first_x;
                r.first_y  = first_y;
                r.first_z  = first_z;
                r.second_x = second_x;
                r.second_y = second_y;
                r.second_z = second_z;
                r.radius   = sphere_radius;
                visible_q.push_back(cull_visible(r));
            end
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] check error: %s", $time, what);
        error_count++;
    endtask

    // Result checker
    always @(posedge clk)
    begin : check_results
        bit want;
        if (rst_n && res_valid && !res_stall)
        begin
            result_count++;
            if (visible_q.size() == 0)
                report_mismatch($sformatf("result %0d with nothing outstanding",
                                          result_count));
            else
            begin
                want = visible_q.pop_front();
                if (visible !== want)
                    report_mismatch($sformatf("result %0d visible %b, predicted %b",
                                              result_count, visible, want));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (res_valid && !res_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(negedge clk)
        res_stall <= ($urandom_range(0, 99) < stall_pct);

    function automatic logic [fct_pkg::CFG_DATA_BITS-1:0] pack_plane(int nx, int ny,
                                                                     int nz, int d);
        return {16'(d), 16'(nz), 16'(ny), 16'(nx)};
    endfunction

    function automatic request_t make_request(logic kind, int fx, int fy, int fz,
                                              int sx, int sy, int sz, int rad);
        request_t r;
        r.req_type = kind;
        r.first_x  = CW'(fx);
        r.first_y  = CW'(fy);
        r.first_z  = CW'(fz);
        r.second_x = CW'(sx);
        r.second_y = CW'(sy);
        r.second_z = CW'(sz);
        r.radius   = (CW-1)'(rad);
        return r;
    endfunction

    function automatic logic signed [CW-1:0] random_coord(int span);
        int v;
        v = $urandom_range(0, 2 * span) - span;
        return CW'(v);
    endfunction

    function automatic request_t random_request(int span);
        request_t r;
        r.req_type = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) < 2)
        begin
            // raw noise over the whole field range
            r.first_x  = CW'($urandom);
            r.first_y  = CW'($urandom);
            r.first_z  = CW'($urandom);
            r.second_x = CW'($urandom);
            r.second_y = CW'($urandom);
            r.second_z = CW'($urandom);
            r.radius   = (CW-1)'($urandom);
        end
        else
        begin
            r.first_x = random_coord(span);
            r.first_y = random_coord(span);
            r.first_z = random_coord(span);
            r.radius  = (CW-1)'($urandom_range(0, span / 2));
            if ($urandom_range(0, 9) == 0)
            begin
                // unordered corners, inverted boxes among them
                r.second_x = random_coord(span);
                r.second_y = random_coord(span);
                r.second_z = random_coord(span);
            end
            else
            begin
                r.second_x = r.first_x + CW'($urandom_range(0, span / 2));
                r.second_y = r.first_y + CW'($urandom_range(0, span / 2));
                r.second_z = r.first_z + CW'($urandom_range(0, span / 2));
            end
        end
        return r;
    endfunction

    function automatic logic [fct_pkg::CFG_DATA_BITS-1:0] random_plane(plane_style_t style);
        int comp [4];
        case (style)
            STYLE_ZERO:
                return '0;
            STYLE_NOISE:
                return {$urandom, $urandom};
            STYLE_EXTREME:
            begin
                foreach (comp[k])
                begin
                    case ($urandom_range(0, 3))
                        0: comp[k] = -32768;
                        1: comp[k] = 32767;
                        2: comp[k] = -1;
                        default: comp[k] = 0;
                    endcase
                end
                return pack_plane(comp[0], comp[1], comp[2], comp[3]);
            end
            default:
            begin
                // unit-ish normal, origin on the inside
                for (int k = 0; k < 3; k++)
                    comp[k] = ($urandom_range(0, 3) == 0) ? 0
                              : int'($urandom_range(0, 2 * ONE_Q14)) - ONE_Q14;
                comp[3] = $urandom_range(200, 4000);
                return pack_plane(comp[0], comp[1], comp[2], comp[3]);
            end
        endcase
    endfunction

    task automatic write_plane(input logic [fct_pkg::CFG_IDX_BITS-1:0] idx,
                               input logic [fct_pkg::CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One request transfer, with random sender gaps ahead of it
    task automatic send_request(input request_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid     <= 1'b1;
        req_type      <= r.req_type;
        first_x       <= r.first_x;
        first_y       <= r.first_y;
        first_z       <= r.first_z;
        second_x      <= r.second_x;
        second_y      <= r.second_y;
        second_z      <= r.second_z;
        sphere_radius <= r.radius;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (visible_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_axis_frustum(input int half);
        write_plane(fct_pkg::PLANE_LEFT,   pack_plane(ONE_Q14, 0, 0, half));
        write_plane(fct_pkg::PLANE_RIGHT,  pack_plane(-ONE_Q14, 0, 0, half));
        write_plane(fct_pkg::PLANE_BOTTOM, pack_plane(0, ONE_Q14, 0, half));
        write_plane(fct_pkg::PLANE_TOP,    pack_plane(0, -ONE_Q14, 0, half));
        write_plane(fct_pkg::PLANE_NEAR,   pack_plane(0, 0, ONE_Q14, half));
        write_plane(fct_pkg::PLANE_FAR,    pack_plane(0, 0, -ONE_Q14, half));
    endtask

    task automatic load_setting(input int which);
        plane_style_t style;
        if (which % 4 == 0)
            load_axis_frustum($urandom_range(300, 3000));
        else
        begin
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++)
            begin
                case (which % 4)
                    1: style = STYLE_SCENE;
                    2: style = plane_style_t'($urandom_range(0, 2));
                    default: style = ($urandom_range(0, 1) == 0) ? STYLE_SCENE
                                                                 : STYLE_EXTREME;
                endcase
                write_plane(fct_pkg::PLANE_IDX[i], random_plane(style));
            end
        end
        // out-of-range writes must leave the planes alone
        write_plane(($urandom_range(0, 1) == 0) ? IDX_SPARE_LO : IDX_SPARE_HI,
                    {$urandom, $urandom});
    endtask

    // Planes straight out of reset accept everything
    task automatic test_reset_planes();
        send_request(make_request(fct_pkg::REQ_SPHERE, -32768, -32768, -32768,
                                  32767, 32767, 32767, 0));
        send_request(make_request(fct_pkg::REQ_SPHERE, 32767, 32767, 32767,
                                  -32768, -32768, -32768, 32767));
        send_request(make_request(fct_pkg::REQ_BOX, 32767, 32767, 32767,
                                  -32768, -32768, -32768, 0));
        send_request(make_request(fct_pkg::REQ_BOX, -32768, -32768, -32768,
                                  32767, 32767, 32767, 32767));
        wait_drained();
    endtask

    // Cube frustum of half size 1000: inside, outside, touching, inverted boxes
    task automatic test_directed_frustum();
        load_axis_frustum(1000);
        send_request(make_request(fct_pkg::REQ_SPHERE, 0, 0, 0, 12345, -77, 9, 0));
        send_request(make_request(fct_pkg::REQ_SPHERE, 1500, 0, 0, 0, 0, 0, 400));
        send_request(make_request(fct_pkg::REQ_SPHERE, 1500, 0, 0, -32768, 32767, -1, 500));
        send_request(make_request(fct_pkg::REQ_SPHERE, -32768, 0, 0, 0, 0, 0, 32767));
        send_request(make_request(fct_pkg::REQ_SPHERE, 32767, 32767, 32767, 0, 0, 0, 0));
        send_request(make_request(fct_pkg::REQ_BOX, -2000, -2000, -2000,
                                  2000, 2000, 2000, 32767));
        send_request(make_request(fct_pkg::REQ_BOX, 1100, 0, 0, 1200, 10, 10, 0));
        send_request(make_request(fct_pkg::REQ_BOX, -32768, -32768, -32768,
                                  32767, 32767, 32767, 0));
        send_request(make_request(fct_pkg::REQ_BOX, 1500, 0, 0, -1500, 0, 0, 100));
        send_request(make_request(fct_pkg::REQ_BOX, -3000, -5, -5, -1000, 5, 5, 0));
        send_request(make_request(fct_pkg::REQ_BOX, -3000, -5, -5, -1001, 5, 5, 32767));
        send_request(make_request(fct_pkg::REQ_BOX, 0, 500, 0, 0, -500, 0, 0));
        wait_drained();
    endtask

    // Whole-register extremes on every plane
    task automatic test_config_extremes();
        logic [fct_pkg::CFG_DATA_BITS-1:0] patterns [4];
        patterns[0] = '1;
        patterns[1] = 64'h8000_8000_8000_8000;
        patterns[2] = 64'h7FFF_7FFF_7FFF_7FFF;
        patterns[3] = 64'h7FFF_8000_0000_7FFF;
        foreach (patterns[p])
        begin
            for (int i = 0; i < fct_pkg::NUM_PLANES; i++)
                write_plane(fct_pkg::PLANE_IDX[i], patterns[p]);
            write_plane(IDX_SPARE_HI, '0);
            for (int n = 0; n < 15; n++)
                send_request(random_request(4096));
            wait_drained();
        end
    endtask

    // Random requests over several plane settings under one idling mix
    task automatic test_random_stream(input int sender_gap, input int recv_stall,
                                      input bit hold_off);
        gap_pct   = sender_gap;
        stall_pct = recv_stall;
        for (int s = 0; s < SETTINGS_PER_PHASE; s++)
        begin
            load_setting(s + $urandom_range(0, 3));
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
            begin
                send_request(random_request((s == 1) ? 8192 : 2048));
                if (hold_off && n == ITEMS_PER_SETTING / 2)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_planes();
        test_directed_frustum();
        test_config_extremes();
        test_random_stream(0, 0, 1'b0);
        test_random_stream(74, 0, 1'b1);
        test_random_stream(0, 74, 1'b0);
        test_random_stream(25, 25, 1'b0);

        gap_pct   = 0;
        stall_pct = 0;
        wait_drained();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
